// File: src/kvs_pkg.sv
// ----------------------------------------------------------------------------
// kvs_pkg: shared types and constants for the keyframe vec3 sampler
// Word layouts of the item and result channels, store write bundle and codes.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int MAX_KEYS_DEF = 64;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam logic REG_TRACK_LEN = 1'b0;
  localparam logic [6:0] TRACK_LEN_RST = 7'd1;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int FRAC_W = 17;  // fraction 0..65536

  typedef struct packed {
    logic        action;
    logic [5:0]  key_slot;
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] query_time;
  } kvs_in_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [6:0]  segment;
  } kvs_out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec3_t;

  typedef struct packed {
    logic        en;
    logic [31:0] key_time;
    vec3_t       val;
  } kvs_wr_t;

endpackage

// File: src/kvs_store.sv
// ----------------------------------------------------------------------------
// kvs_store: key time and key value memories
// One write port and one registered read port, shared address for both arrays.
// ----------------------------------------------------------------------------
module kvs_store #(
  parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF,
  parameter int AW       = 6
) (
  input  logic            clk,
  input  kvs_pkg::kvs_wr_t wr,
  input  logic [AW-1:0]   wr_addr,
  input  logic [AW-1:0]   rd_addr,
  output logic [31:0]     rd_time,
  output kvs_pkg::vec3_t  rd_val
);
  import kvs_pkg::*;

  logic [31:0] time_mem [MAX_KEYS];
  vec3_t       val_mem  [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      time_mem[wr_addr] <= wr.key_time;
      val_mem[wr_addr]  <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    rd_time <= time_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
  end

endmodule

// File: src/kvs_frac_div.sv
// ----------------------------------------------------------------------------
// kvs_frac_div: iterative fraction divider
// Computes floor(num * 65536 / den) for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kvs_frac_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [kvs_pkg::FRAC_W-1:0] frac
);
  import kvs_pkg::*;

  logic [31:0]       rem_r;
  logic [31:0]       den_r;
  logic [FRAC_W-1:0] nbits_r;
  logic [FRAC_W-1:0] quo_r;
  logic [4:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [32:0]       trial;
  logic              fits;

  // shift in the next numerator bit, subtract when the divisor fits
  assign trial = {rem_r, nbits_r[FRAC_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd1);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'(FRAC_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // high bits of num * 65536 above the quotient range start the remainder
      rem_r   <= {1'b0, num[31:1]};
      nbits_r <= {num[0], {(FRAC_W-1){1'b0}}};
      quo_r   <= '0;
      den_r   <= den;
    end else if (run_r) begin
      rem_r   <= fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      nbits_r <= {nbits_r[FRAC_W-2:0], 1'b0};
      quo_r   <= {quo_r[FRAC_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign frac = quo_r;

endmodule

// File: src/kvs_blend.sv
// ----------------------------------------------------------------------------
// kvs_blend: shared two-stage lerp unit
// res = a + floor((b - a) * frac / 65536); one component accepted per cycle.
// ----------------------------------------------------------------------------
module kvs_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [kvs_pkg::FRAC_W-1:0] frac,
  output logic        out_valid,
  output logic [31:0] res
);
  import kvs_pkg::*;

  logic signed [32:0] diff;
  logic signed [50:0] prod_r;
  logic [31:0]        a_d_r;
  logic [31:0]        res_r;
  logic               v1_r;
  logic               v2_r;

  assign diff = $signed({b[31], b}) - $signed({a[31], a});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 51'(diff) * 51'($signed({1'b0, frac}));
    a_d_r  <= a;
    // arithmetic shift floors; only the low 32 bits of the sum survive
    res_r  <= a_d_r + prod_r[47:16];
  end

  assign out_valid = v2_r;
  assign res       = res_r;

endmodule

// File: src/keyframe_vec3_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler: linear keyframe sampler for a vec3 animation track
//
// Item channel: a word is taken at a clock edge with start high and busy low.
//   A load word (action 0) writes time and x, y, z into key slot key_slot in
//   that one cycle and gives no result; busy stays low.
//   A query word (action 1) scans the first track-length times for the first
//   key at or after query_time, then returns the clamped end value or the
//   lerp between the two bracketing keys.
// Result channel: out_valid is high for one cycle with out_word; the
//   receiver cannot stall it, and it lands in the cycle busy drops.
// Query sequence: each key scanned passes a read state and a compare state (one
//   read port on the time store); an end value then passes S_EDGE and S_EOUT,
//   while an interpolation runs the bit-serial fraction divider, then x, y, z
//   through one shared multiplier.
// Throughput: one query at a time; the next word can be taken in the cycle
//   that carries the result.
// Config: APB register track_len at address 0 (reset 1); write while idle.
// Reset: control clears; key stores hold garbage until loaded.
// ----------------------------------------------------------------------------
module keyframe_vec3_sampler #(
  parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  kvs_pkg::kvs_in_t           in_word,
  output logic                       out_valid,
  output kvs_pkg::kvs_out_t          out_word,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kvs_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import kvs_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int IW = $clog2(MAX_KEYS + 1);
  localparam int CW = (IW > 7) ? IW : 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_EOUT  = 4'd4;
  localparam logic [3:0] S_LDA   = 4'd5;
  localparam logic [3:0] S_LDB   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DWAIT = 4'd8;
  localparam logic [3:0] S_BLEND = 4'd9;
  localparam logic [3:0] S_BWAIT = 4'd10;

  logic [3:0]  state_r;
  logic [6:0]  track_len_r;
  logic [IW-1:0] cnt_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] seg_r;
  logic [31:0] q_r;
  logic [31:0] ta_r;
  logic [31:0] tb_r;
  vec3_t       va_r;
  vec3_t       vb_r;
  logic [1:0]  comp_r;
  logic [1:0]  col_r;
  logic [31:0] rx_r;
  logic [31:0] ry_r;
  logic        out_valid_r;
  kvs_out_t    out_word_r;

  logic          accept;
  logic          cfg_wr;
  logic [CW-1:0] kc_w;
  logic [IW-1:0] cnt_eff;
  logic [IW-1:0] im1;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_time;
  vec3_t         rd_val;
  kvs_wr_t       wr;
  logic          div_start;
  logic          div_done;
  logic [FRAC_W-1:0] div_frac;
  logic          bl_in_valid;
  logic [31:0]   bl_a;
  logic [31:0]   bl_b;
  logic          bl_valid;
  logic [31:0]   bl_res;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_TRACK_LEN);
  assign prdata = (paddr[CFG_AW-1] == REG_TRACK_LEN) ? {25'd0, track_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_len_r <= TRACK_LEN_RST;
    end else if (cfg_wr) begin
      track_len_r <= pwdata[6:0];
    end
  end

  // clamp the programmed count into 1..MAX_KEYS
  assign kc_w = CW'(track_len_r);
  always_comb begin
    if (kc_w == '0) begin
      cnt_eff = IW'(1);
    end else if (kc_w > CW'(MAX_KEYS)) begin
      cnt_eff = IW'(MAX_KEYS);
    end else begin
      cnt_eff = IW'(kc_w);
    end
  end

  // ---- key store
  assign wr.en       = accept && (in_word.action == ACT_LOAD) &&
                       (CW'(in_word.key_slot) < CW'(MAX_KEYS));
  assign wr.key_time = in_word.key_time;
  assign wr.val.x    = in_word.key_x;
  assign wr.val.y    = in_word.key_y;
  assign wr.val.z    = in_word.key_z;

  assign im1     = i_r - IW'(1);
  assign rd_addr = (state_r == S_LDA) ? im1[AW-1:0] : i_r[AW-1:0];

  kvs_store #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (AW'(in_word.key_slot)),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_val  (rd_val)
  );

  // ---- fraction divider
  assign div_start = (state_r == S_DIV);

  kvs_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (q_r - ta_r),
    .den   (tb_r - ta_r),
    .done  (div_done),
    .frac  (div_frac)
  );

  // ---- shared blend unit, one component per cycle
  assign bl_in_valid = (state_r == S_BLEND);
  always_comb begin
    case (comp_r)
      2'd0:    begin bl_a = va_r.x; bl_b = vb_r.x; end
      2'd1:    begin bl_a = va_r.y; bl_b = vb_r.y; end
      default: begin bl_a = va_r.z; bl_b = vb_r.z; end
    endcase
  end

  kvs_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bl_in_valid),
    .a         (bl_a),
    .b         (bl_b),
    .frac      (div_frac),
    .out_valid (bl_valid),
    .res       (bl_res)
  );

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      comp_r      <= '0;
      col_r       <= '0;
    end else begin
      out_valid_r <= (state_r == S_EOUT) ||
                     ((state_r == S_BWAIT) && bl_valid && (col_r == 2'd2));
      case (state_r)
        S_IDLE: begin
          if (accept && (in_word.action == ACT_QUERY)) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (q_r <= rd_time) begin
            state_r <= (i_r == '0) ? S_EDGE : S_LDA;
          end else if ((i_r + IW'(1)) == cnt_r) begin
            state_r <= S_EDGE;
          end else begin
            state_r <= S_RD;
          end
        end
        S_EDGE: begin
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          state_r <= S_IDLE;
        end
        S_LDA: begin
          state_r <= S_LDB;
        end
        S_LDB: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            comp_r  <= '0;
            state_r <= S_BLEND;
          end
        end
        S_BLEND: begin
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd2) begin
            state_r <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (bl_valid && (col_r == 2'd2)) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (bl_valid) begin
        col_r <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r   <= in_word.query_time;
        cnt_r <= cnt_eff;
        i_r   <= '0;
      end
      S_CMP: begin
        if (q_r <= rd_time) begin
          seg_r <= i_r;
          tb_r  <= rd_time;
        end else begin
          ta_r <= rd_time;
          if ((i_r + IW'(1)) == cnt_r) begin
            seg_r <= cnt_r;  // past the last key: hold i_r on the last slot
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
      end
      S_EOUT: begin
        out_word_r.out_x   <= rd_val.x;
        out_word_r.out_y   <= rd_val.y;
        out_word_r.out_z   <= rd_val.z;
        out_word_r.segment <= 7'(seg_r);
      end
      S_LDB: begin
        va_r <= rd_val;
      end
      S_DIV: begin
        vb_r <= rd_val;
      end
      default: begin
      end
    endcase

    if (bl_valid) begin
      case (col_r)
        2'd0:    rx_r <= bl_res;
        2'd1:    ry_r <= bl_res;
        default: begin
          out_word_r.out_x   <= rx_r;
          out_word_r.out_y   <= ry_r;
          out_word_r.out_z   <= bl_res;
          out_word_r.segment <= 7'(seg_r);
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: src/kvs_checker.sv
// ----------------------------------------------------------------------------
// kvs_checker: port-level checks for the keyframe vec3 sampler
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module kvs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input kvs_pkg::kvs_in_t  in_word,
  input logic              out_valid,
  input kvs_pkg::kvs_out_t out_word
);
  import kvs_pkg::*;

  // a query always occupies the block past the accept edge
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.action == ACT_QUERY) |=> busy)
    else $error("query accepted without going busy");

  // a load finishes in its own cycle
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.action == ACT_LOAD) |=> !busy && !out_valid)
    else $error("load held the block or produced a result");

  // the result strobe lands exactly when busy drops
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result strobe while busy or repeated");

endmodule

bind keyframe_vec3_sampler kvs_checker u_kvs_checker (.*);

// File: tb/kvs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kvs_scoreboard: scoreboard for the keyframe vec3 sampler
// Watches the item, result and register ports, keeps its own key track,
// predicts every query sample and compares each result word against it.
// ----------------------------------------------------------------------------
module kvs_scoreboard (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  kvs_pkg::kvs_in_t           in_word,
  input  logic                       out_valid,
  input  kvs_pkg::kvs_out_t          out_word,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [kvs_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output int                         fail_count,
  output int                         pending
);
  import kvs_pkg::*;

  localparam int KEYS = MAX_KEYS_DEF;
  localparam logic [CFG_AW-1:0] TRACK_LEN_ADDR = CFG_AW'(4 * REG_TRACK_LEN);

  logic [31:0] key_times [KEYS];
  vec3_t       key_vals  [KEYS];
  logic [6:0]  track_len;
  kvs_out_t    sample_q [$];

  // a + floor((b - a) * f / 65536), exact in 64 bits
  function automatic logic [31:0] lerp_comp(logic [31:0] a, logic [31:0] b,
                                            logic [16:0] f);
    longint sa, diff, prod;
    sa   = longint'($signed(a));
    diff = longint'($signed(b)) - sa;
    prod = diff * longint'(f);
    return 32'(sa + (prod >>> 16));
  endfunction

  function automatic kvs_out_t sample_track(logic [31:0] q);
    int          cnt, seg;
    logic [31:0] dq, dt;
    logic [63:0] num, quo;
    logic [16:0] frac;
    vec3_t       va, vb;
    kvs_out_t    r;
    cnt = int'(track_len);
    if (cnt < 1) cnt = 1;
    if (cnt > KEYS) cnt = KEYS;
    // first key at or after q, scanning from the top keeps the lowest index
    seg = cnt;
    for (int i = cnt - 1; i >= 0; i--) begin
      if (q <= key_times[i]) seg = i;
    end
    if (seg == 0) begin
      va = key_vals[0];
    end else if (seg == cnt) begin
      va = key_vals[cnt-1];
    end else begin
      dq  = q - key_times[seg-1];
      dt  = key_times[seg] - key_times[seg-1];
      num = {16'd0, dq, 16'd0};
      if (dt == 32'd0) begin
        frac = '0;
      end else begin
        quo  = num / {32'd0, dt};
        frac = (quo > 64'd65536) ? 17'd65536 : quo[16:0];
      end
      vb   = key_vals[seg];
      va   = key_vals[seg-1];
      va.x = lerp_comp(va.x, vb.x, frac);
      va.y = lerp_comp(va.y, vb.y, frac);
      va.z = lerp_comp(va.z, vb.z, frac);
    end
    r.out_x   = va.x;
    r.out_y   = va.y;
    r.out_z   = va.z;
    r.segment = 7'(seg);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    kvs_out_t exp_w;
    if (!rst_n) begin
      sample_q.delete();
      track_len = TRACK_LEN_RST;
    end else begin
      // retire the result word before taking a new query in the same edge
      if (out_valid) begin
        if (sample_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_word);
        end else begin
          exp_w = sample_q.pop_front();
          check_field("out_x", exp_w.out_x, out_word.out_x);
          check_field("out_y", exp_w.out_y, out_word.out_y);
          check_field("out_z", exp_w.out_z, out_word.out_z);
          check_field("segment", {25'd0, exp_w.segment}, {25'd0, out_word.segment});
        end
      end
      if (start && !busy) begin
        if (in_word.action == ACT_LOAD) begin
          key_times[in_word.key_slot] = in_word.key_time;
          key_vals[in_word.key_slot]  = '{in_word.key_x, in_word.key_y, in_word.key_z};
        end else begin
          sample_q.push_back(sample_track(in_word.query_time));
        end
      end
      if (psel && penable && pwrite && pready && paddr == TRACK_LEN_ADDR)
        track_len = pwdata[6:0];
    end
    pending <= sample_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the keyframe vec3 sampler
// Loads key tracks, programs the key count across its range, and sends
// directed then random load and query words with random gaps. A checker
// beside the block predicts and compares every sample.
// ----------------------------------------------------------------------------
module tb_top;
  import kvs_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 1000;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam logic [CFG_AW-1:0] TRACK_LEN_ADDR = CFG_AW'(4 * REG_TRACK_LEN);

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  kvs_in_t           in_word = '0;
  logic              out_valid;
  kvs_out_t          out_word;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          pending;
  int          cycles      = 0;
  int          words_sent  = 0;
  int          trk_n       = 1;
  logic [31:0] trk_t [64];

  always #5 clk = ~clk;

  keyframe_vec3_sampler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  kvs_scoreboard u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("keyframe_vec3_sampler verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    logic [31:0] mag;
    mag = $urandom_range(0, 32'h3_FFFF);
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return ($urandom_range(0, 1) != 0) ? mag : -mag;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_query_time();
    int          k;
    logic [31:0] lo, hi;
    k  = $urandom_range(0, trk_n - 1);
    lo = trk_t[k];
    hi = (k + 1 < trk_n) ? trk_t[k+1] : 32'hFFFF_FFFF;
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return lo - 32'd1;
      2:       return lo + 32'd1;
      3:       return lo + (hi - lo) / 2;
      4:       return 32'd0;
      5:       return 32'hFFFF_FFFF;
      6:       return (hi > lo) ? lo + $urandom_range(0, hi - lo) : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Hold the word until it is taken, dropping start at random cycles outside the quiet window
  task automatic send_word(input kvs_in_t w);
    bit quiet;
    quiet = (words_sent >= QUIET_FROM && words_sent < QUIET_TO);
    in_word <= w;
    forever begin
      start <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
      @(posedge clk);
      if (start && !busy) break;
    end
    words_sent++;
  endtask

  task automatic load_key(input int slot, input logic [31:0] t,
                          input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    kvs_in_t w;
    w.action     = ACT_LOAD;
    w.key_slot   = 6'(slot);
    w.key_time   = t;
    w.key_x      = x;
    w.key_y      = y;
    w.key_z      = z;
    w.query_time = $urandom;
    trk_t[slot]  = t;
    send_word(w);
  endtask

  task automatic query_at(input logic [31:0] q);
    kvs_in_t w;
    w.action     = ACT_QUERY;
    w.key_slot   = 6'($urandom);
    w.key_time   = $urandom;
    w.key_x      = $urandom;
    w.key_y      = $urandom;
    w.key_z      = $urandom;
    w.query_time = q;
    send_word(w);
  endtask

  // Drain every pending sample and let the block go idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_track_len(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TRACK_LEN_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    trk_n = (v[6:0] == 7'd0) ? 1 : (v[6:0] > 7'd64) ? 64 : int'(v[6:0]);
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] cfg_v;
    logic [6:0]  cnt;
    longint      gapmax, acc;
    bit          sorted;
    int          nq, goal;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every slot so no query ever reads an unwritten key
    for (int i = 0; i < 64; i++) load_key(i, 32'(i) << 16, rand_comp(), rand_comp(), rand_comp());

    // reset count of one: before and past the single key
    query_at(32'd0);
    query_at(32'hFFFF_FFFF);

    // extreme values, duplicate times, bracket ends
    settle();
    write_track_len(32'd4);
    load_key(0, 32'h0000_1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    load_key(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    load_key(2, 32'h8000_0000, 32'd1, 32'd2, 32'd3);
    load_key(3, 32'hFFFF_FFFF, -32'sd5, 32'd5, 32'h7FFF_FFFF);
    query_at(32'd0);
    query_at(32'h0000_1000);
    query_at(32'h0000_1001);
    query_at(32'h4000_0000);
    query_at(32'h8000_0000);
    query_at(32'h8000_0001);
    query_at(32'hFFFF_FFFF);
    settle();
    write_track_len(32'd3);
    query_at(32'hFFFF_FFFF);

    // unsorted track
    settle();
    write_track_len(32'd4);
    load_key(0, 32'd10, 32'd1000, -32'sd1000, 32'h0001_0000);
    load_key(1, 32'd50, -32'sd7, 32'd7, 32'h8000_0000);
    load_key(2, 32'd5, 32'h7FFF_0000, 32'd0, 32'd1);
    load_key(3, 32'd100, 32'h8000_0001, 32'h1234_5678, -32'sd1);
    query_at(32'd7);
    query_at(32'd60);
    query_at(32'd101);
    query_at(32'd50);

    // count zero acts as one, and 127 with upper bits set acts as 64
    settle();
    write_track_len(32'd0);
    query_at(32'h0000_0020);
    query_at(32'hFFFF_FFFF);
    settle();
    write_track_len(32'hFFFF_FFFF);
    query_at(32'hFFFF_FFFF);
    query_at(32'h0020_0008);

    goal = words_sent + RANDOM_ITEMS;
    while (words_sent < goal) begin
      settle();
      case ($urandom_range(0, 9))
        0:       cnt = 7'd1;
        1:       cnt = 7'd64;
        2:       cnt = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
        8, 9:    cnt = 7'($urandom_range(9, 64));
        default: cnt = 7'($urandom_range(2, 8));
      endcase
      cfg_v      = $urandom;
      cfg_v[6:0] = cnt;
      write_track_len(cfg_v);

      // load a fresh track, mostly sorted
      sorted = $urandom_range(0, 99) < 85;
      case ($urandom_range(0, 2))
        0:       gapmax = 3;
        1:       gapmax = 64'h2_0000;
        default: gapmax = 64'hFFFF_FFFF / (trk_n + 1);
      endcase
      acc = $urandom_range(0, 32'(gapmax));
      for (int i = 0; i < trk_n; i++) begin
        load_key(i, sorted ? acc[31:0] : $urandom, rand_comp(), rand_comp(), rand_comp());
        acc += $urandom_range(0, 32'(gapmax));
      end

      nq = $urandom_range(4, 30);
      repeat (nq) begin
        if ($urandom_range(0, 99) < 10)
          load_key($urandom_range(0, 63), $urandom, rand_comp(), rand_comp(), rand_comp());
        else
          query_at(pick_query_time());
        if ($urandom_range(0, 99) < 3) settle();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("keyframe_vec3_sampler verification clean");
    else
      $display("keyframe_vec3_sampler verification failed");
    $finish;
  end

endmodule
